// File: hdl/pft_pkg.sv
// pft_pkg: types, codes and sizes shared by the packet filter rule table
// used by pft_match, packet_filter_rule_table
`default_nettype none

package pft_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_NO_ID = 2'd3;

	localparam logic [1:0] DIR_NONE   = 2'd0;
	localparam logic [1:0] DIR_INPUT  = 2'd1;
	localparam logic [1:0] DIR_OUTPUT = 2'd2;
	localparam logic [1:0] DIR_BAD    = 2'd3;

	localparam logic [1:0] VERD_UNSET = 2'd0;
	localparam logic [1:0] VERD_BAD   = 2'd3;

	localparam logic [7:0] PROTO_ICMP = 8'd1;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] rule_id;
		logic [1:0]  direction;
		logic [7:0]  in_iface;
		logic [7:0]  out_iface;
		logic [7:0]  protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [1:0]  verdict_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] hit_id;
		logic [1:0]  verdict;
		logic [1:0]  hit_direction;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [1:0]  dir;
		logic [7:0]  iif;
		logic [7:0]  oif;
		logic [7:0]  proto;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [1:0]  verdict;
	} rule_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WAIT,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// File: hdl/pft_rule_ram.sv
// pft_rule_ram: generic single write port, single read port synchronous ram
// with registered read data, no dependencies
`default_nettype none

module pft_rule_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/pft_match.sv
// pft_match: decides whether one stored rule hits a lookup transaction
// depends on pft_pkg
`default_nettype none

module pft_match
	import pft_pkg::*;
(
	input  wire rule_t rule,
	input  wire req_t  req,
	output logic       hit
);

	function automatic logic chain_match(
		input logic [7:0]  r_if,
		input logic [7:0]  p_if,
		input logic [7:0]  r_pr,
		input logic [7:0]  p_pr,
		input logic [15:0] r_port,
		input logic [15:0] p_port,
		input logic [31:0] r_ip,
		input logic [31:0] p_ip
	);
		logic ok;
		logic port_bad;
		logic ip_bad;
		ok = 1'b0;
		port_bad = (p_pr != PROTO_ICMP) && (r_port != 16'd0) && (r_port != p_port);
		ip_bad = (r_ip != 32'd0) && (r_ip != p_ip);
		if (r_if != 8'd0 && p_if != 8'd0) begin
			if (r_if == p_if) begin
				ok = 1'b1;
				if (r_pr != 8'd0 && p_pr != 8'd0) begin
					if (r_pr != p_pr || port_bad) begin
						ok = 1'b0;
					end
				end
				if (ip_bad) begin
					ok = 1'b0;
				end
			end
		end else if (r_pr != 8'd0 && p_pr != 8'd0) begin
			ok = (r_pr == p_pr) && !port_bad && !ip_bad;
		end else if (r_ip != 32'd0) begin
			ok = (r_ip == p_ip);
		end
		return ok;
	endfunction

	always_comb begin
		hit = 1'b0;
		if (rule.id == req.rule_id) begin
			hit = 1'b1;
		end else if (req.direction == DIR_INPUT && rule.dir == DIR_INPUT) begin
			hit = chain_match(rule.iif, req.in_iface, rule.proto, req.protocol,
				rule.dport, req.dst_port, rule.sip, req.src_ip);
		end else if (req.direction == DIR_OUTPUT && rule.dir == DIR_OUTPUT) begin
			hit = chain_match(rule.oif, req.out_iface, rule.proto, req.protocol,
				rule.sport, req.src_port, rule.dip, req.dst_ip);
		end
	end

endmodule

`default_nettype wire

// File: hdl/packet_filter_rule_table.sv
// packet_filter_rule_table: first-match firewall rule table, top level
// depends on pft_pkg, pft_rule_ram, pft_match
//
// Holds up to TABLE_DEPTH rules in a one-port-read synchronous ram with a
// valid bit per slot in flops. Insert and clear go from acceptance straight
// to the done state; lookup and delete read every slot once, one per cycle,
// through the ram read port, then pass a wait state before the done state.
// One transaction is worked at a time; a new one is taken as soon as the
// previous result sits in the output register, even if it is stalled.
// No clearing pass is needed after reset.
`default_nettype none

module packet_filter_rule_table
	import pft_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	state_t state_q, state_d;

	req_t               req_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [15:0]        next_id_q;
	logic [IDX_W-1:0]   cnt_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [15:0]        best_id_q;
	logic [1:0]         best_verd_q;
	logic [1:0]         best_dir_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               accept;
	logic               load;
	logic               cnt_last;
	logic               ram_we;
	rule_t              wr_rule;
	rule_t              rd_rule;
	logic [$bits(rule_t)-1:0] rd_bits;
	logic               match_hit;
	logic               slot_hit;
	logic               free_found;
	logic [IDX_W-1:0]   free_idx;
	rsp_t               result;
	logic               ins_ok;

	assign accept = req_valid && !req_stall;
	assign cnt_last = (cnt_q == IDX_W'(TABLE_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req_stall = 1'b1;
		load = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (req.action == ACT_LOOKUP || req.action == ACT_DELETE) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (cnt_last) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		wr_rule.id = next_id_q;
		wr_rule.dir = (req_q.direction == DIR_BAD) ? DIR_NONE : req_q.direction;
		wr_rule.iif = req_q.in_iface;
		wr_rule.oif = req_q.out_iface;
		wr_rule.proto = req_q.protocol;
		wr_rule.sip = req_q.src_ip;
		wr_rule.dip = req_q.dst_ip;
		wr_rule.sport = req_q.src_port;
		wr_rule.dport = req_q.dst_port;
		wr_rule.verdict = (req_q.verdict_in == VERD_BAD) ? VERD_UNSET : req_q.verdict_in;
	end

	assign ins_ok = (next_id_q != 16'd0) && free_found;
	assign ram_we = load && (req_q.action == ACT_INSERT) && ins_ok;

	pft_rule_ram #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH($bits(rule_t))
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx),
		.wdata(wr_rule),
		.raddr(cnt_q),
		.rdata(rd_bits)
	);

	assign rd_rule = rd_bits;

	pft_match u_match (
		.rule(rd_rule),
		.req (req_q),
		.hit (match_hit)
	);

	assign slot_hit = rd_vld_s1 && valid_q[rd_idx_s1] &&
		((req_q.action == ACT_LOOKUP) ? match_hit : (rd_rule.id == req_q.rule_id));

	always_comb begin
		result = '0;
		case (req_q.action)
			ACT_LOOKUP, ACT_DELETE: begin
				if (found_q) begin
					result.status = ST_OK;
					result.hit_id = best_id_q;
					result.verdict = best_verd_q;
					result.hit_direction = best_dir_q;
				end else begin
					result.status = ST_MISS;
				end
			end
			ACT_INSERT: begin
				if (next_id_q == 16'd0) begin
					result.status = ST_NO_ID;
				end else if (!free_found) begin
					result.status = ST_FULL;
				end else begin
					result.status = ST_OK;
					result.hit_id = next_id_q;
					result.verdict = wr_rule.verdict;
					result.hit_direction = wr_rule.dir;
				end
			end
			ACT_CLEAR: begin
				result.status = ST_OK;
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			next_id_q <= 16'd1;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			if (accept) begin
				cnt_q <= '0;
				found_q <= 1'b0;
			end else if (state_q == S_SCAN && !cnt_last) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			if (slot_hit && (!found_q || rd_rule.id < best_id_q)) begin
				found_q <= 1'b1;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (load) begin
				case (req_q.action)
					ACT_INSERT: begin
						if (ins_ok) begin
							valid_q[free_idx] <= 1'b1;
							next_id_q <= next_id_q + 16'd1;
						end
					end
					ACT_DELETE: begin
						if (found_q) begin
							valid_q[best_idx_q] <= 1'b0;
						end
					end
					ACT_CLEAR: begin
						valid_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		if (accept) begin
			req_q <= req;
		end
		if (slot_hit && (!found_q || rd_rule.id < best_id_q)) begin
			best_idx_q <= rd_idx_s1;
			best_id_q <= rd_rule.id;
			best_verd_q <= rd_rule.verdict;
			best_dir_q <= rd_rule.dir;
		end
		if (load) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_insert_fills: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> $countones(valid_q) == $past($countones(valid_q)) + 1)
		else $error("insert did not fill exactly one slot");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(load && req_q.action == ACT_CLEAR) |=> valid_q == '0)
		else $error("clear left valid slots");

	a_miss_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_OK) |-> rsp.hit_id == 16'd0)
		else $error("failed transaction carries a rule id");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_WAIT) |-> req_stall && !load)
		else $error("new transaction taken during a scan");
`endif

endmodule

`default_nettype wire
